@@ hw/rtl/drs_pkg.sv @@
// ----------------------------------------------------------------------------
// drs_pkg
// Shared types, constants and the sort-key function of the date sorter.
// ----------------------------------------------------------------------------
package drs_pkg;

  localparam int MAX_ITEMS  = 64;
  localparam int RADIX      = 256;
  localparam int KEY_DIGITS = 4;

  localparam int ALL_DIGITS = 4;
  localparam int DIGIT_W    = (RADIX > 1) ? $clog2(RADIX) : 1;
  localparam int KEY_W      = ALL_DIGITS * DIGIT_W;
  localparam int COUNT_W    = $clog2(MAX_ITEMS + 1);

  typedef struct packed {
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } date_t;

  typedef logic [KEY_W-1:0] key_t;

  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctl_t;

  typedef enum logic [0:0] {
    ST_LOAD,
    ST_EMIT
  } state_t;

  // Digits from least significant: day, month, year low, year high.
  // Digits below the key range compare equal.
  function automatic key_t sort_key(date_t d);
    logic [DIGIT_W-1:0] dg [ALL_DIGITS];
    key_t               k;
    dg[0] = DIGIT_W'(32'(d.day) % RADIX);
    dg[1] = DIGIT_W'(32'(d.month) % RADIX);
    dg[2] = DIGIT_W'(32'(d.year) % RADIX);
    dg[3] = DIGIT_W'((32'(d.year) / RADIX) % RADIX);
    k = '0;
    for (int s = 0; s < ALL_DIGITS; s++) begin
      if (s >= ALL_DIGITS - KEY_DIGITS) begin
        k[s*DIGIT_W +: DIGIT_W] = dg[s];
      end
    end
    return k;
  endfunction

endpackage

@@ hw/rtl/drs_cell.sv @@
// ----------------------------------------------------------------------------
// drs_cell
// One slot of the insertion chain: holds a date, takes the new date or its
// left neighbor's on insert, takes its right neighbor's on shift-out.
// ----------------------------------------------------------------------------
module drs_cell (
  input  logic              clk,
  input  logic              rst,
  input  drs_pkg::cell_ctl_t ctl,
  input  drs_pkg::date_t    new_date,
  input  drs_pkg::key_t     new_key,
  input  drs_pkg::date_t    prev_date,
  input  logic              prev_valid,
  input  logic              prev_less,
  input  drs_pkg::date_t    next_date,
  input  logic              next_valid,
  output drs_pkg::date_t    date,
  output logic              valid,
  output logic              less
);
  import drs_pkg::*;

  date_t date_next;
  logic  valid_next;

  // New date sorts before this slot; empty slots act as +infinity.
  assign less = !valid || (new_key < sort_key(date));

  always_comb begin
    date_next  = date;
    valid_next = valid;
    if (ctl.insert && less) begin
      if (prev_less) begin
        date_next  = prev_date;
        valid_next = prev_valid;
      end else begin
        date_next  = new_date;
        valid_next = 1'b1;
      end
    end else if (ctl.shift) begin
      date_next  = next_date;
      valid_next = next_valid;
    end
  end

  always_ff @(posedge clk) begin
    date <= date_next;
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

endmodule

@@ hw/rtl/date_radix_sorter.sv @@
// ----------------------------------------------------------------------------
// date_radix_sorter
// Batch date sorter built as a chain of insertion cells.
// ----------------------------------------------------------------------------
// Dates are taken one per cycle while in_ready is high and are placed in
// sorted position at once by a row of MAX_ITEMS cells, each comparing the
// incoming date with its own and shifting right where needed; equal dates
// keep arrival order. The transfer marked last_item ends the batch; the
// sorted dates then leave one per cycle from the head cell while out_ready
// is high; in_ready is low meanwhile. Dates beyond MAX_ITEMS are dropped
// and overflowed is set on that batch's results.
// ----------------------------------------------------------------------------
module date_radix_sorter (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] year,
  input  logic [3:0]  month,
  input  logic [4:0]  day,
  input  logic        last_item,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] sorted_year,
  output logic [3:0]  sorted_month,
  output logic [4:0]  sorted_day,
  output logic        final_out,
  output logic        overflowed
);
  import drs_pkg::*;

  state_t             state, state_next;
  logic [COUNT_W-1:0] count, count_next;
  logic               dropped, dropped_next;
  cell_ctl_t          ctl;
  date_t              new_date;
  key_t               new_key;
  logic               in_xfer, out_xfer, full;

  date_t cell_date  [MAX_ITEMS];
  logic  cell_valid [MAX_ITEMS];
  logic  cell_less  [MAX_ITEMS];

  assign new_date = '{year: year, month: month, day: day};
  assign new_key  = sort_key(new_date);
  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;
  assign full     = (count == COUNT_W'(MAX_ITEMS));

  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD: begin
        if (in_xfer && last_item) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_xfer && final_out) begin
          state_next = ST_LOAD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    ctl.insert = 1'b0;
    ctl.shift  = 1'b0;
    case (state)
      ST_LOAD: begin
        in_ready   = 1'b1;
        ctl.insert = in_valid && !full;
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        ctl.shift = out_ready;
      end
      default: ;
    endcase
  end

  always_comb begin
    count_next   = count;
    dropped_next = dropped;
    if (in_xfer) begin
      if (full) begin
        dropped_next = 1'b1;
      end else begin
        count_next = count + COUNT_W'(1);
      end
    end else if (out_xfer) begin
      count_next = count - COUNT_W'(1);
      if (final_out) begin
        dropped_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_LOAD;
      count   <= '0;
      dropped <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      dropped <= dropped_next;
    end
  end

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    date_t p_date, n_date;
    logic  p_valid, p_less, n_valid;
    if (i == 0) begin : g_head
      assign p_date  = '0;
      assign p_valid = 1'b0;
      assign p_less  = 1'b0;
    end else begin : g_body
      assign p_date  = cell_date[i-1];
      assign p_valid = cell_valid[i-1];
      assign p_less  = cell_less[i-1];
    end
    if (i == MAX_ITEMS - 1) begin : g_tail
      assign n_date  = '0;
      assign n_valid = 1'b0;
    end else begin : g_link
      assign n_date  = cell_date[i+1];
      assign n_valid = cell_valid[i+1];
    end
    drs_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .new_date   (new_date),
      .new_key    (new_key),
      .prev_date  (p_date),
      .prev_valid (p_valid),
      .prev_less  (p_less),
      .next_date  (n_date),
      .next_valid (n_valid),
      .date       (cell_date[i]),
      .valid      (cell_valid[i]),
      .less       (cell_less[i])
    );
  end

  assign sorted_year  = cell_date[0].year;
  assign sorted_month = cell_date[0].month;
  assign sorted_day   = cell_date[0].day;
  assign final_out    = (count == COUNT_W'(1));
  assign overflowed   = dropped;

  a_emit_has_data: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (count != '0) && cell_valid[0])
    else $error("emitting with an empty chain");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(MAX_ITEMS))
    else $error("item count above capacity");

  a_final_clears: assert property (@(posedge clk) disable iff (rst)
    out_xfer && final_out |=> in_ready && (count == '0) && !dropped && !cell_valid[0])
    else $error("batch not cleared after final transfer");

  a_drop_flag: assert property (@(posedge clk) disable iff (rst)
    in_xfer && full |=> dropped)
    else $error("dropped date not flagged");

endmodule
